FILE: design/lwh_pkg.sv
// ----------------------------------------------------------------------------
// lwh_pkg: shared types and constants for the link wake handshake controller
// Event codes, phase encoding, wake line actions and result bundle.
// ----------------------------------------------------------------------------
package lwh_pkg;

	localparam int REQ_W    = 3;
	localparam int PHASE_W  = 4;
	localparam int ACTION_W = 2;
	localparam int INACT_W  = 16;
	localparam int SETTLE_W = 8;
	localparam int CFG_W    = 16;

	localparam logic [INACT_W-1:0]  INACT_RESET  = 16'd1000;
	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd1;

	// configuration register indexes
	localparam logic CFG_INACT  = 1'b0;
	localparam logic CFG_SETTLE = 1'b1;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK    = 3'd0,
		REQ_PARTNER = 3'd1,
		REQ_TX      = 3'd2,
		REQ_RX      = 3'd3,
		REQ_POWER   = 3'd4,
		REQ_FLUSHED = 3'd5,
		REQ_STOP    = 3'd6,
		REQ_UNUSED  = 3'd7   // no meaning; reports state only
	} req_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE   = 4'd0,
		PH_POWER  = 4'd1,
		PH_UP     = 4'd2,
		PH_TXIDLE = 4'd3,
		PH_FLUSH  = 4'd4,
		PH_RXIDLE = 4'd5,
		PH_DOWN   = 4'd6,
		PH_SETTLE = 4'd7,
		PH_STOP   = 4'd8
	} phase_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE    = 2'd0,
		ACT_RAISE   = 2'd1,
		ACT_PREPARE = 2'd2,
		ACT_LOWER   = 2'd3
	} action_t;

	// partner wake line tracking
	typedef struct packed {
		logic rise;
		logic fall;
		logic seen_high;
	} edge_t;

	typedef struct packed {
		logic        edge_warning;
		logic        flush_request;
		logic        start_tx;
		logic        may_transmit;
		action_t     wake_action;
		phase_t      link_state;
	} result_t;

endpackage

FILE: design/lwh_edge.sv
// ----------------------------------------------------------------------------
// lwh_edge: partner wake line edge latching
// Latches rising/falling reports, recovers a missed opposite edge, flags
// inconsistent reports.
// ----------------------------------------------------------------------------
module lwh_edge (
	input  lwh_pkg::edge_t cur,
	input  logic           partner_evt,
	input  logic           level,
	output lwh_pkg::edge_t nxt,
	output logic           warn
);
	import lwh_pkg::*;

	always_comb begin
		nxt  = cur;
		warn = 1'b0;
		if (partner_evt) begin
			if (level) begin
				// second rise without a fall: the fall was missed
				if (cur.seen_high) begin
					warn     = 1'b1;
					nxt.fall = 1'b1;
				end
				if (cur.rise)
					warn = 1'b1;
				nxt.seen_high = 1'b1;
				nxt.rise      = 1'b1;
			end else begin
				// fall without a rise: the rise was missed
				if (!cur.seen_high) begin
					warn     = 1'b1;
					nxt.rise = 1'b1;
				end
				if (cur.fall)
					warn = 1'b1;
				nxt.seen_high = 1'b0;
				nxt.fall      = 1'b1;
			end
		end
	end

endmodule

FILE: design/lwh_fsm.sv
// ----------------------------------------------------------------------------
// lwh_fsm: link phase state machine
// Holds phase, activity flags, edge latches and tick timer; produces the
// result for the event presented when step is high.
// ----------------------------------------------------------------------------
module lwh_fsm #(
	parameter int TIMER_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [lwh_pkg::REQ_W-1:0]        req,
	input  logic                             level,
	input  logic [lwh_pkg::INACT_W-1:0]      inactivity_ticks,
	input  logic [lwh_pkg::SETTLE_W-1:0]     settle_ticks,
	output lwh_pkg::result_t                 res
);
	import lwh_pkg::*;

	localparam int CMP_W = (TIMER_BITS > INACT_W) ? TIMER_BITS : INACT_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	phase_t                phase_q, phase_d;
	edge_t                 edge_q, edge_upd, edge_d;
	logic                  tx_busy_q, tx_busy_d;
	logic                  rx_seen_q, rx_seen_d;
	logic                  power_ok_q, power_ok_d;
	logic                  link_up_q, link_up_d;
	logic [TIMER_BITS-1:0] wait_q, wait_d, wait_inc;
	logic                  inact_exp, settle_exp, warn;
	action_t               action;
	logic                  start, flush;

	lwh_edge u_edge (
		.cur         (edge_q),
		.partner_evt (req == REQ_PARTNER),
		.level       (level),
		.nxt         (edge_upd),
		.warn        (warn)
	);

	// saturating tick counter; saturated counts as expired
	assign wait_inc   = (wait_q != TIMER_MAX) ? wait_q + 1'b1 : wait_q;
	assign inact_exp  = (CMP_W'(wait_inc) >= CMP_W'(inactivity_ticks)) ||
	                    (wait_inc == TIMER_MAX);
	assign settle_exp = (CMP_W'(wait_inc) >= CMP_W'(settle_ticks)) ||
	                    (wait_inc == TIMER_MAX);

	always_comb begin
		phase_d    = phase_q;
		edge_d     = edge_upd;
		tx_busy_d  = tx_busy_q;
		rx_seen_d  = rx_seen_q;
		power_ok_d = power_ok_q;
		link_up_d  = link_up_q;
		wait_d     = wait_q;
		action     = ACT_NONE;
		start      = 1'b0;
		flush      = 1'b0;

		unique case (req)
			REQ_TX:    tx_busy_d  = level;
			REQ_RX:    rx_seen_d  = 1'b1;
			REQ_POWER: power_ok_d = level;
			REQ_STOP: begin
				phase_d   = PH_STOP;
				link_up_d = 1'b0;
			end
			default: ;
		endcase

		// stop and the unused code take no step of the phase case below
		if (req != REQ_STOP && req != REQ_UNUSED) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (edge_d.rise || tx_busy_d) begin
						if (power_ok_d) begin
							phase_d = PH_UP;
							action  = ACT_RAISE;
						end else begin
							phase_d = PH_POWER;
						end
					end
				end
				PH_POWER: begin
					if (power_ok_d) begin
						phase_d = PH_UP;
						action  = ACT_RAISE;
					end
				end
				PH_UP: begin
					if (edge_d.rise) begin
						edge_d.rise = 1'b0;
						link_up_d   = 1'b1;
						start       = tx_busy_d;
						phase_d     = PH_TXIDLE;
					end
				end
				PH_TXIDLE: begin
					if (!tx_busy_d) begin
						flush   = 1'b1;
						phase_d = PH_FLUSH;
					end
				end
				PH_FLUSH: begin
					if (req == REQ_FLUSHED) begin
						rx_seen_d = 1'b0;
						wait_d    = '0;
						phase_d   = PH_RXIDLE;
					end
				end
				PH_RXIDLE: begin
					if (tx_busy_d) begin
						phase_d = PH_TXIDLE;
					end else if (rx_seen_d) begin
						rx_seen_d = 1'b0;
						wait_d    = '0;
					end else if (req == REQ_TICK) begin
						wait_d = wait_inc;
						if (inact_exp) begin
							link_up_d = 1'b0;
							action    = ACT_PREPARE;
							phase_d   = PH_DOWN;
						end
					end
				end
				PH_DOWN: begin
					if (edge_d.fall) begin
						edge_d.fall = 1'b0;
						action      = ACT_LOWER;
						wait_d      = '0;
						phase_d     = PH_SETTLE;
					end
				end
				PH_SETTLE: begin
					if (req == REQ_TICK) begin
						wait_d = wait_inc;
						if (settle_exp)
							phase_d = PH_IDLE;
					end
				end
				default: ;
			endcase
		end

		res.link_state    = phase_d;
		res.wake_action   = action;
		res.may_transmit  = link_up_d;
		res.start_tx      = start;
		res.flush_request = flush;
		res.edge_warning  = warn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			edge_q     <= '0;
			tx_busy_q  <= 1'b0;
			rx_seen_q  <= 1'b0;
			power_ok_q <= 1'b1;
			link_up_q  <= 1'b0;
			wait_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			edge_q     <= edge_d;
			tx_busy_q  <= tx_busy_d;
			rx_seen_q  <= rx_seen_d;
			power_ok_q <= power_ok_d;
			link_up_q  <= link_up_d;
			wait_q     <= wait_d;
		end
	end

endmodule

FILE: design/link_wake_handshake_fsm.sv
// ----------------------------------------------------------------------------
// link_wake_handshake_fsm: wake/sleep handshake controller for a modem link
// Pipeline: the accepting edge loads the input register; the result register
//   loads from it once the result stage is free, and m_tvalid rises with it.
// Throughput: one transaction per cycle while m_tready is high; a held result
//   stalls stage 1, and a full stage 1 then drops s_tready.
// Reset (arst_n low, async): phase idle, latches and flags clear, power ok
//   set, timer zero, inactivity 1000 ticks, settle 1 tick, both stages empty.
// ----------------------------------------------------------------------------
module link_wake_handshake_fsm #(
	parameter int TIMER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// event stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [0] level, [7:1] zero
	input  logic [2:0]  s_tuser,    // [2:0] req_type
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [3:0] link_state, [5:4] wake_action,
	                                // [6] may_transmit, [7] start_tx,
	                                // [8] flush_request, [9] edge_warning,
	                                // [15:10] zero
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_index,  // 0 inactivity_ticks, 1 settle_ticks
	input  logic [lwh_pkg::CFG_W-1:0] cfg_data
);
	import lwh_pkg::*;

	logic [INACT_W-1:0]  inact_q;
	logic [SETTLE_W-1:0] settle_q;

	logic             valid_s1;
	logic [REQ_W-1:0] req_s1;
	logic             level_s1;

	logic             valid_s2;
	result_t          res_s2;
	result_t          res_next;

	logic             advance;   // result stage free to take a new result
	logic             step;      // the item in stage 1 updates state now

	// Stages move when the result stage is empty or being taken; a result
	// held by the sink stalls stage 1, which then holds off the input.
	assign advance  = !valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// configuration registers, written only while the block is idle: a rule for the user that the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inact_q  <= INACT_RESET;
			settle_q <= SETTLE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_INACT)
				inact_q <= cfg_data;
			else
				settle_q <= cfg_data[SETTLE_W-1:0];
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1   <= s_tuser;
			level_s1 <= s_tdata[0];
		end
	end

	// phase machine: state advances exactly once per transaction, in order
	lwh_fsm #(
		.TIMER_BITS (TIMER_BITS)
	) u_fsm (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.req              (req_s1),
		.level            (level_s1),
		.inactivity_ticks (inact_q),
		.settle_ticks     (settle_q),
		.res              (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_s2 <= res_next;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2};

endmodule

FILE: tb/tb_link_wake_handshake_fsm.sv
// ----------------------------------------------------------------------------
// tb_link_wake_handshake_fsm: self-checking bench for the link wake controller
// A short table of hand-picked events, then state-aware random event streams,
// scored against a cycle-free handshake model kept in the bench; typed rows use want.
// The register settings cover extremes, zero and a long timer run.
// ----------------------------------------------------------------------------
module tb_link_wake_handshake_fsm;
	import lwh_pkg::*;

	localparam logic [REQ_W-1:0] REQ_BAD = REQ_UNUSED;  // code with no meaning
	localparam int               LATENCY = 2;
	localparam int               CYCLE_LIMIT = 400000;
	localparam logic [15:0]      TIMER_TOP = 16'hFFFF;  // TIMER_BITS = 16
	localparam result_t          QUIET_IDLE = '{1'b0, 1'b0, 1'b0, 1'b0, ACT_NONE, PH_IDLE};

	// one row of the directed table; want is used only where typed is set
	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             lvl;
		logic             typed;
		result_t          want;
	} row_t;

	localparam int N_ROWS = 24;

	// walk: power gating, rise, doubled rise, flush, rx restart, timer expiry,
	// doubled fall, settle, stale rise from idle, missed edge, tx back-off
	row_t dir_tab [N_ROWS] = '{
		'{REQ_TICK,    1'b0, 1'b1, QUIET_IDLE},  // fresh out of reset
		'{REQ_BAD,     1'b1, 1'b1, QUIET_IDLE},  // unknown code
		'{REQ_FLUSHED, 1'b1, 1'b1, QUIET_IDLE},  // flush done outside flush
		'{REQ_POWER,   1'b0, 1'b1, QUIET_IDLE},  // nothing to wake for yet
		'{REQ_TX,      1'b1, 1'b0, QUIET_IDLE},  // tx busy, power low
		'{REQ_POWER,   1'b1, 1'b0, QUIET_IDLE},
		'{REQ_PARTNER, 1'b1, 1'b0, QUIET_IDLE},
		'{REQ_PARTNER, 1'b1, 1'b0, QUIET_IDLE},  // second rise in a row
		'{REQ_RX,      1'b0, 1'b0, QUIET_IDLE},
		'{REQ_TX,      1'b0, 1'b0, QUIET_IDLE},
		'{REQ_TICK,    1'b1, 1'b0, QUIET_IDLE},
		'{REQ_FLUSHED, 1'b0, 1'b0, QUIET_IDLE},
		'{REQ_RX,      1'b1, 1'b0, QUIET_IDLE},
		'{REQ_TICK,    1'b0, 1'b0, QUIET_IDLE},
		'{REQ_TICK,    1'b1, 1'b0, QUIET_IDLE},
		'{REQ_PARTNER, 1'b0, 1'b0, QUIET_IDLE},  // fall already latched
		'{REQ_TICK,    1'b0, 1'b0, QUIET_IDLE},
		'{REQ_TICK,    1'b0, 1'b0, QUIET_IDLE},  // stale rise wakes us
		'{REQ_TICK,    1'b1, 1'b0, QUIET_IDLE},
		'{REQ_PARTNER, 1'b0, 1'b0, QUIET_IDLE},  // fall with no rise seen
		'{REQ_FLUSHED, 1'b1, 1'b0, QUIET_IDLE},
		'{REQ_TX,      1'b1, 1'b0, QUIET_IDLE},
		'{REQ_TX,      1'b0, 1'b0, QUIET_IDLE},
		'{REQ_BAD,     1'b0, 1'b0, QUIET_IDLE}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int bad_cnt = 0;

	result_t want_q [$];
	result_t chk_got;
	result_t chk_want;

	// bench copy of the controller state and registers
	phase_t          pr_phase = PH_IDLE;
	logic            pr_rise = 1'b0;
	logic            pr_fall = 1'b0;
	logic            pr_high = 1'b0;
	logic            pr_tx = 1'b0;
	logic            pr_rx = 1'b0;
	logic            pr_pwr = 1'b1;
	logic            pr_up = 1'b0;
	logic [15:0]     pr_wait = '0;
	logic [INACT_W-1:0]  inact_lim = INACT_RESET;
	logic [SETTLE_W-1:0] settle_lim = SETTLE_RESET;

	link_wake_handshake_fsm uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// saturating wait counter; a saturated count is treated as expired
	function automatic logic timer_done(input logic [15:0] limit);
		if (pr_wait != TIMER_TOP)
			pr_wait++;
		return (pr_wait >= limit) || (pr_wait == TIMER_TOP);
	endfunction

	// apply one event to the bench state and return the result it produces
	function automatic result_t predict_wake(input logic [REQ_W-1:0] req, input logic lvl);
		result_t r;
		action_t act;
		logic    start, flush, warn;

		act = ACT_NONE;
		start = 1'b0;
		flush = 1'b0;
		warn = 1'b0;

		// latch partner edges; a report at the level already held means
		// the opposite edge was missed, so recover it and warn
		case (req)
		REQ_PARTNER: begin
			if (lvl) begin
				if (pr_high) begin
					warn = 1'b1;
					pr_fall = 1'b1;
				end
				pr_high = 1'b1;
				if (pr_rise)
					warn = 1'b1;
				pr_rise = 1'b1;
			end else begin
				if (!pr_high) begin
					warn = 1'b1;
					pr_rise = 1'b1;
				end
				pr_high = 1'b0;
				if (pr_fall)
					warn = 1'b1;
				pr_fall = 1'b1;
			end
		end
		REQ_TX: pr_tx = lvl;
		REQ_RX: pr_rx = 1'b1;
		REQ_POWER: pr_pwr = lvl;
		REQ_STOP: begin
			pr_phase = PH_STOP;
			pr_up = 1'b0;
		end
		default: ;
		endcase

		// at most one phase step per event
		if (req != REQ_BAD && req != REQ_STOP) begin
			case (pr_phase)
			PH_IDLE: begin
				if (pr_rise || pr_tx) begin
					if (pr_pwr) begin
						pr_phase = PH_UP;
						act = ACT_RAISE;
					end else begin
						pr_phase = PH_POWER;
					end
				end
			end
			PH_POWER: begin
				if (pr_pwr) begin
					pr_phase = PH_UP;
					act = ACT_RAISE;
				end
			end
			PH_UP: begin
				if (pr_rise) begin
					pr_rise = 1'b0;
					pr_up = 1'b1;
					start = pr_tx;
					pr_phase = PH_TXIDLE;
				end
			end
			PH_TXIDLE: begin
				if (!pr_tx) begin
					flush = 1'b1;
					pr_phase = PH_FLUSH;
				end
			end
			PH_FLUSH: begin
				if (req == REQ_FLUSHED) begin
					pr_rx = 1'b0;
					pr_wait = '0;
					pr_phase = PH_RXIDLE;
				end
			end
			PH_RXIDLE: begin
				if (pr_tx) begin
					pr_phase = PH_TXIDLE;
				end else if (pr_rx) begin
					pr_rx = 1'b0;
					pr_wait = '0;
				end else if (req == REQ_TICK) begin
					if (timer_done(inact_lim)) begin
						pr_up = 1'b0;
						act = ACT_PREPARE;
						pr_phase = PH_DOWN;
					end
				end
			end
			PH_DOWN: begin
				if (pr_fall) begin
					pr_fall = 1'b0;
					act = ACT_LOWER;
					pr_wait = '0;
					pr_phase = PH_SETTLE;
				end
			end
			PH_SETTLE: begin
				if (req == REQ_TICK) begin
					if (timer_done({8'd0, settle_lim}))
						pr_phase = PH_IDLE;
				end
			end
			default: ;
			endcase
		end

		r.link_state = pr_phase;
		r.wake_action = act;
		r.may_transmit = pr_up;
		r.start_tx = start;
		r.flush_request = flush;
		r.edge_warning = warn;
		return r;
	endfunction

	// register write, only issued with the pipeline empty
	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_INACT)
			inact_lim = val;
		else
			settle_lim = val[SETTLE_W-1:0];
	endtask

	// offer one event; valid stays up afterwards until the next call or a drain
	task automatic send_event(input logic [REQ_W-1:0] req, input logic lvl,
			input logic typed, input result_t want);
		result_t pred;

		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {7'd0, lvl};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = predict_wake(req, lvl);
		want_q.push_back(typed ? want : pred);
	endtask

	// hold the sender off until every pending result is back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (want_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// mostly the event that moves the handshake along, some noise
	task automatic pick_event(output logic [REQ_W-1:0] req, output logic lvl,
			input int noise_pct, input int rx_pct);
		lvl = 1'($urandom_range(1));
		if ($urandom_range(99) < noise_pct) begin
			do
				req = 3'($urandom_range(7));
			while (req == REQ_STOP);
		end else begin
			case (pr_phase)
			PH_IDLE: begin
				if ($urandom_range(3) == 0) begin
					req = REQ_TX;
					lvl = 1'b1;
				end else begin
					req = REQ_PARTNER;
					lvl = !pr_high;
				end
			end
			PH_POWER: begin
				req = REQ_POWER;
				lvl = 1'b1;
			end
			PH_UP, PH_DOWN: begin
				// toggle the partner line; the wanted edge comes within two
				req = REQ_PARTNER;
				lvl = !pr_high;
			end
			PH_TXIDLE: begin
				req = REQ_TX;
				lvl = 1'b0;
			end
			PH_FLUSH: req = REQ_FLUSHED;
			PH_RXIDLE: req = ($urandom_range(99) < rx_pct) ? REQ_RX : REQ_TICK;
			default: req = REQ_TICK;
			endcase
		end
	endtask

	task automatic run_random(input int count, input int noise_pct, input int rx_pct);
		logic [REQ_W-1:0] r;
		logic             l;

		repeat (count) begin
			pick_event(r, l, noise_pct, rx_pct);
			send_event(r, l, 1'b0, QUIET_IDLE);
		end
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= snk_idle_pct);

	// score every result transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			chk_got = result_t'(m_tdata[9:0]);
			if (want_q.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= 10)
					$display("unexpected result transaction: data %h", m_tdata);
			end else begin
				chk_want = want_q.pop_front();
				if (chk_got.link_state !== chk_want.link_state ||
						chk_got.wake_action !== chk_want.wake_action ||
						chk_got.may_transmit !== chk_want.may_transmit ||
						chk_got.start_tx !== chk_want.start_tx ||
						chk_got.flush_request !== chk_want.flush_request ||
						chk_got.edge_warning !== chk_want.edge_warning ||
						m_tdata[15:10] !== 6'd0) begin
					bad_cnt++;
					if (bad_cnt <= 10) begin
						$display("mismatch (exp/act): state %0d/%0d action %0d/%0d xmit %b/%b",
							chk_want.link_state, chk_got.link_state,
							chk_want.wake_action, chk_got.wake_action,
							chk_want.may_transmit, chk_got.may_transmit);
						$display("  start %b/%b flush %b/%b warn %b/%b pad 0/%h",
							chk_want.start_tx, chk_got.start_tx,
							chk_want.flush_request, chk_got.flush_request,
							chk_want.edge_warning, chk_got.edge_warning,
							m_tdata[15:10]);
					end
				end
			end
		end
	end

	initial begin : watchdog
		int cycles;

		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : main
		int               n;
		logic [REQ_W-1:0] r;
		logic             l;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed table, sender 38% idle, receiver 46% idle
		src_idle_pct = 38;
		snk_idle_pct = 46;
		write_reg(CFG_INACT, 16'd2);
		write_reg(CFG_SETTLE, 16'd1);
		for (n = 0; n < N_ROWS; n++)
			send_event(dir_tab[n].req, dir_tab[n].lvl, dir_tab[n].typed, dir_tab[n].want);
		drain();

		// shortest inactivity, longest settle
		write_reg(CFG_INACT, 16'd1);
		write_reg(CFG_SETTLE, 16'd255);
		run_random(350, 15, 20);
		drain();

		// zero timers expire on the first tick; idling swapped
		src_idle_pct = 46;
		snk_idle_pct = 38;
		write_reg(CFG_INACT, 16'd0);
		write_reg(CFG_SETTLE, 16'd0);
		run_random(350, 20, 15);
		drain();

		// mid-range timers, no idling, one full hold-off halfway
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_reg(CFG_INACT, 16'($urandom_range(3, 20)));
		write_reg(CFG_SETTLE, 16'($urandom_range(2, 6)));
		run_random(150, 15, 25);
		drain();
		run_random(150, 15, 25);
		drain();

		// long inactivity: one uninterrupted tick run up to expiry
		write_reg(CFG_INACT, 16'd250);
		write_reg(CFG_SETTLE, 16'd255);
		for (n = 0; n < 1000 && pr_phase != PH_DOWN; n++) begin
			pick_event(r, l, 0, 0);
			send_event(r, l, 1'b0, QUIET_IDLE);
		end
		run_random(50, 0, 0);
		drain();

		// stop is terminal; later events only touch latches and flags
		send_event(REQ_STOP, 1'b1, 1'b0, QUIET_IDLE);
		send_event(REQ_PARTNER, 1'b1, 1'b0, QUIET_IDLE);
		send_event(REQ_PARTNER, 1'b1, 1'b0, QUIET_IDLE);
		send_event(REQ_PARTNER, 1'b0, 1'b0, QUIET_IDLE);
		send_event(REQ_TX, 1'b1, 1'b0, QUIET_IDLE);
		send_event(REQ_POWER, 1'b0, 1'b0, QUIET_IDLE);
		send_event(REQ_POWER, 1'b1, 1'b0, QUIET_IDLE);
		send_event(REQ_RX, 1'b0, 1'b0, QUIET_IDLE);
		send_event(REQ_TICK, 1'b0, 1'b0, QUIET_IDLE);
		send_event(REQ_FLUSHED, 1'b1, 1'b0, QUIET_IDLE);
		send_event(REQ_BAD, 1'b1, 1'b0, QUIET_IDLE);
		send_event(REQ_STOP, 1'b0, 1'b0, QUIET_IDLE);
		drain();

		if (bad_cnt == 0 && want_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
design/lwh_pkg.sv
design/lwh_edge.sv
design/lwh_fsm.sv
design/link_wake_handshake_fsm.sv
tb/tb_link_wake_handshake_fsm.sv
